@@ rtl/ihex_pkg.sv @@
// shared constants and types for the hex record parser
// no dependencies; used by ihex_in_stage, ihex_decode and the top level
`default_nettype none

package ihex_pkg;

	// address width of the produced writes, and the wrap mask that follows from it
	localparam int AddressBits = 32;
	localparam logic [31:0] AddrMask = 32'hFFFF_FFFF >> (32 - AddressBits);

	// characters with a meaning of their own
	localparam logic [7:0] CharColon   = 8'h3A;
	localparam logic [7:0] CharNewline = 8'h0A;

	// record kinds
	localparam logic [7:0] KindData    = 8'h00;
	localparam logic [7:0] KindSegment = 8'h02;
	localparam logic [7:0] KindLinear  = 8'h04;

	// one registered character on its way into the decoder
	typedef struct packed {
		logic       valid;
		logic [7:0] character;
	} stage_t;

endpackage

`default_nettype wire

@@ rtl/ihex_in_stage.sv @@
// input register of the hex record parser: holds one accepted character
// depends on ihex_pkg (stage_t)
`default_nettype none

module ihex_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            char_valid,
	output logic                 char_stall,
	input  wire logic [7:0]      character,
	input  wire logic            advance,
	output ihex_pkg::stage_t     stage_s1
);

	logic load;

	// take a new request whenever the held one is empty or moves on
	assign load       = !stage_s1.valid || advance;
	assign char_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1.valid     <= 1'b0;
			stage_s1.character <= 8'h00;
		end else if (load) begin
			stage_s1.valid <= char_valid;
			if (char_valid) begin
				stage_s1.character <= character;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ihex_decode.sv @@
// line state machine and result register of the hex record parser
// depends on ihex_pkg (constants, stage_t)
`default_nettype none

module ihex_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ihex_pkg::stage_t  stage_s1,
	output logic                   advance,
	output logic                   write_valid,
	input  wire logic              write_stall,
	output logic [31:0]            write_address,
	output logic [7:0]             write_data
);

	typedef enum logic [2:0] {
		PH_START,
		PH_COUNT,
		PH_ADDR,
		PH_TYPE,
		PH_DATA,
		PH_EXT,
		PH_SKIP
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  digit_q, digit_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  kind_q, kind_d;
	logic [15:0] load_addr_q, load_addr_d;
	logic [7:0]  bytes_q, bytes_d;
	logic [15:0] acc_q, acc_d;
	logic [31:0] offset_q, offset_d;
	logic        res_valid;
	logic [31:0] res_address;
	logic [15:0] acc_shift;
	logic [7:0]  bytes_inc;
	logic        take;

	// hex digit value; anything else counts as its low nibble
	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [3:0] v;
		if (c inside {[8'h41:8'h46]} || c inside {[8'h61:8'h66]}) begin
			v = c[3:0] + 4'd9;
		end else begin
			v = c[3:0];
		end
		return v;
	endfunction

	// result register empty or being taken: the held character is processed
	assign advance = !write_valid || !write_stall;
	assign take    = advance && stage_s1.valid;

	assign acc_shift   = {acc_q[11:0], digit_value(stage_s1.character)};
	assign bytes_inc   = bytes_q + 8'd1;
	assign res_address = (32'(load_addr_q) + offset_q + 32'(bytes_q)) & ihex_pkg::AddrMask;

	// next state for one character
	always_comb begin
		phase_d     = phase_q;
		digit_d     = digit_q;
		length_d    = length_q;
		kind_d      = kind_q;
		load_addr_d = load_addr_q;
		bytes_d     = bytes_q;
		acc_d       = acc_q;
		offset_d    = offset_q;
		res_valid   = 1'b0;
		if (stage_s1.character == ihex_pkg::CharNewline) begin
			phase_d = PH_START;
			digit_d = 2'd0;
			acc_d   = 16'h0000;
		end else begin
			case (phase_q)
				PH_START: begin
					if (stage_s1.character == ihex_pkg::CharColon) begin
						phase_d = PH_COUNT;
						digit_d = 2'd0;
						acc_d   = 16'h0000;
						bytes_d = 8'd0;
					end else begin
						phase_d = PH_SKIP;
					end
				end
				PH_COUNT: begin
					acc_d   = acc_shift;
					digit_d = digit_q + 2'd1;
					if (digit_q == 2'd1) begin
						length_d = acc_shift[7:0];
						phase_d  = PH_ADDR;
						digit_d  = 2'd0;
						acc_d    = 16'h0000;
					end
				end
				PH_ADDR: begin
					acc_d   = acc_shift;
					digit_d = digit_q + 2'd1;
					if (digit_q == 2'd3) begin
						load_addr_d = acc_shift;
						phase_d     = PH_TYPE;
						digit_d     = 2'd0;
						acc_d       = 16'h0000;
					end
				end
				PH_TYPE: begin
					acc_d   = acc_shift;
					digit_d = digit_q + 2'd1;
					if (digit_q == 2'd1) begin
						kind_d  = acc_shift[7:0];
						digit_d = 2'd0;
						acc_d   = 16'h0000;
						if (acc_shift[7:0] == ihex_pkg::KindData) begin
							phase_d = (length_q != 8'd0) ? PH_DATA : PH_SKIP;
						end else if (acc_shift[7:0] == ihex_pkg::KindSegment ||
						             acc_shift[7:0] == ihex_pkg::KindLinear) begin
							phase_d = PH_EXT;
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
				PH_DATA: begin
					acc_d   = acc_shift;
					digit_d = digit_q + 2'd1;
					if (digit_q == 2'd1) begin
						res_valid = 1'b1;
						bytes_d   = bytes_inc;
						digit_d   = 2'd0;
						acc_d     = 16'h0000;
						phase_d   = (bytes_inc == length_q) ? PH_SKIP : PH_DATA;
					end
				end
				PH_EXT: begin
					acc_d   = acc_shift;
					digit_d = digit_q + 2'd1;
					if (digit_q == 2'd3) begin
						if (kind_q == ihex_pkg::KindSegment) begin
							offset_d = {12'h000, acc_shift, 4'h0};
						end else begin
							offset_d = {acc_shift, 16'h0000};
						end
						phase_d = PH_SKIP;
						digit_d = 2'd0;
						acc_d   = 16'h0000;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			digit_q       <= 2'd0;
			length_q      <= 8'd0;
			kind_q        <= 8'd0;
			load_addr_q   <= 16'h0000;
			bytes_q       <= 8'd0;
			acc_q         <= 16'h0000;
			offset_q      <= 32'h0000_0000;
			write_valid   <= 1'b0;
			write_address <= 32'h0000_0000;
			write_data    <= 8'h00;
		end else begin
			if (advance) begin
				write_valid <= take && res_valid;
			end
			if (take) begin
				phase_q     <= phase_d;
				digit_q     <= digit_d;
				length_q    <= length_d;
				kind_q      <= kind_d;
				load_addr_q <= load_addr_d;
				bytes_q     <= bytes_d;
				acc_q       <= acc_d;
				offset_q    <= offset_d;
				if (res_valid) begin
					write_address <= res_address;
					write_data    <= acc_shift[7:0];
				end
			end
		end
	end

	// a newline always returns to the start of a line
	a_newline_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && stage_s1.character == ihex_pkg::CharNewline
		|=> phase_q == PH_START && digit_q == 2'd0)
		else $error("newline did not return to start of line");

	// results come only from data digits
	a_result_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q != PH_DATA |=> !write_valid)
		else $error("result produced outside a data record");

	// in a data record the byte index stays below the byte count
	a_bytes_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> bytes_q < length_q)
		else $error("byte index reached byte count inside data");

	// two-digit fields never pass their second digit
	a_short_fields: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COUNT || phase_q == PH_TYPE || phase_q == PH_DATA
		|-> digit_q <= 2'd1)
		else $error("digit position past a two-digit field");

endmodule

`default_nettype wire

@@ rtl/intel_hex_record_parser.sv @@
// Intel HEX record parser, top level.
// Channels: char_valid/char_stall/character carries one ASCII character per
// request; write_valid/write_stall/write_address/write_data carries one memory
// write per decoded data byte. A request is taken at a rising edge with valid
// high and stall low. Data records (type 00) produce one write per byte at
// load address + offset + byte index, wrapped to the address width; types 02
// and 04 set the offset; other lines and characters produce nothing.
// A data character that completes a byte passes two registers, input and then
// result, before its write shows. Throughput: one character per cycle while
// the receiver does not stall, set by the single pass through the line state
// machine between the input and result registers.
// When the receiver stalls, the held write stays and one more character may
// wait in the input register; after that char_stall rises.
// Reset (arst_n low) empties both registers, clears the offset and returns the
// parser to the start of a line; no clearing pass is needed.
// depends on ihex_pkg, ihex_in_stage, ihex_decode
`default_nettype none

module intel_hex_record_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire logic [7:0]  character,
	output logic             write_valid,
	input  wire logic        write_stall,
	output logic [31:0]      write_address,
	output logic [7:0]       write_data
);

	ihex_pkg::stage_t stage_s1;
	logic             advance;

	// input register
	ihex_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.character  (character),
		.advance    (advance),
		.stage_s1   (stage_s1)
	);

	// record state machine and write register
	ihex_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.stage_s1      (stage_s1),
		.advance       (advance),
		.write_valid   (write_valid),
		.write_stall   (write_stall),
		.write_address (write_address),
		.write_data    (write_data)
	);

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// testbench for intel_hex_record_parser: character stream in, memory writes out
// depends on ihex_pkg and the parser rtl; self-checking against a built-in line decoder
`timescale 1ns / 100ps

module tb_top;

	localparam int RandomChars = 1450;
	localparam int IdleLimit   = 2000;
	localparam int HoldOff     = 96;
	localparam int DirRows     = 28;

	typedef enum logic [2:0] {
		LN_START, LN_COUNT, LN_ADDR, LN_KIND, LN_DATA, LN_OFFSET, LN_SKIP
	} line_state_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [7:0]  data;
	} mem_write_t;

	typedef struct packed {
		logic [7:0] ch;
		bit         typed;
		mem_write_t w;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	logic [7:0]  character;
	logic        write_valid;
	logic        write_stall;
	logic [31:0] write_address;
	logic [7:0]  write_data;

	// decoder copy of the parser state
	line_state_t ln_state  = LN_START;
	logic [1:0]  dig_idx   = '0;
	logic [7:0]  rec_len   = '0;
	logic [7:0]  rec_kind  = '0;
	logic [15:0] rec_addr  = '0;
	logic [7:0]  byte_idx  = '0;
	logic [15:0] field_acc = '0;
	logic [31:0] base_off  = '0;

	mem_write_t  pending_writes [$];
	logic [7:0]  line_buf [$];
	dir_row_t    dir_rows [DirRows];

	int unsigned errors        = 0;
	int unsigned chars_sent    = 0;
	int unsigned chars_parsed  = 0;
	int unsigned writes_seen   = 0;
	int unsigned offset_loads  = 0;
	int unsigned idle_cycles   = 0;
	int unsigned cycles        = 0;
	bit          pressure_done = 1'b0;

	intel_hex_record_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.character    (character),
		.write_valid  (write_valid),
		.write_stall  (write_stall),
		.write_address(write_address),
		.write_data   (write_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hex digit value; anything that is not a letter digit counts (code - 48) mod 16
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] t;
		if (c >= "A" && c <= "F") begin
			t = c - "A" + 8'd10;
		end else if (c >= "a" && c <= "f") begin
			t = c - "a" + 8'd10;
		end else begin
			t = c - 8'd48;
		end
		return t[3:0];
	endfunction

	task automatic open_field(input line_state_t s);
		ln_state  = s;
		dig_idx   = '0;
		field_acc = '0;
	endtask

	// advance the line decoder by one character, give the write it causes
	task automatic decode_char(input logic [7:0] c, output bit wr, output mem_write_t w);
		logic [15:0] acc;
		wr = 1'b0;
		w  = '0;
		if (c == ihex_pkg::CharNewline) begin
			open_field(LN_START);
		end else if (ln_state == LN_START) begin
			if (c == ihex_pkg::CharColon) begin
				open_field(LN_COUNT);
				byte_idx = '0;
			end else begin
				ln_state = LN_SKIP;
			end
		end else if (ln_state != LN_SKIP) begin
			acc = {field_acc[11:0], nibble_of(c)};
			field_acc = acc;
			case (ln_state)
				LN_COUNT: begin
					if (dig_idx == 2'd1) begin
						rec_len = acc[7:0];
						open_field(LN_ADDR);
					end else begin
						dig_idx++;
					end
				end
				LN_ADDR: begin
					if (dig_idx == 2'd3) begin
						rec_addr = acc;
						open_field(LN_KIND);
					end else begin
						dig_idx++;
					end
				end
				LN_KIND: begin
					if (dig_idx == 2'd1) begin
						rec_kind = acc[7:0];
						if (rec_kind == ihex_pkg::KindData) begin
							open_field(rec_len != 8'd0 ? LN_DATA : LN_SKIP);
						end else if (rec_kind == ihex_pkg::KindSegment ||
								rec_kind == ihex_pkg::KindLinear) begin
							open_field(LN_OFFSET);
						end else begin
							open_field(LN_SKIP);
						end
					end else begin
						dig_idx++;
					end
				end
				LN_DATA: begin
					if (dig_idx == 2'd1) begin
						w.addr = (32'(rec_addr) + base_off + 32'(byte_idx)) &
							ihex_pkg::AddrMask;
						w.data = acc[7:0];
						wr = 1'b1;
						byte_idx++;
						open_field(byte_idx == rec_len ? LN_SKIP : LN_DATA);
					end else begin
						dig_idx++;
					end
				end
				default: begin
					if (dig_idx == 2'd3) begin
						if (rec_kind == ihex_pkg::KindSegment) begin
							base_off = {12'd0, acc, 4'd0};
						end else begin
							base_off = {acc, 16'd0};
						end
						offset_loads++;
						open_field(LN_SKIP);
					end else begin
						dig_idx++;
					end
				end
			endcase
		end
	endtask

	function automatic dir_row_t row(input logic [7:0] c);
		return {c, 1'b0, 40'd0};
	endfunction

	function automatic dir_row_t row_w(input logic [7:0] c, input logic [31:0] a,
			input logic [7:0] d);
		return {c, 1'b1, a, d};
	endfunction

	// sender gap: mostly none, a few long, and whole stretches without any
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((chars_sent / 160) % 4 == 2) return 0;
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic int sink_stall();
		int r;
		r = $urandom_range(0, 99);
		if ((cycles / 500) % 4 == 1) return 0;
		if (r < 70) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 99) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// offer one character, wait for the request to be taken, predict what it causes
	task automatic send_char(input logic [7:0] c, input bit typed, input mem_write_t typed_w);
		bit         wr;
		mem_write_t w;
		int         gap;
		@(negedge clk);
		char_valid <= 1'b1;
		character  <= c;
		forever begin
			@(posedge clk);
			if (!char_stall) break;
		end
		if (ln_state != LN_SKIP) chars_parsed++;
		chars_sent++;
		decode_char(c, wr, w);
		if (typed) begin
			pending_writes.push_back(typed_w);
		end else if (wr) begin
			pending_writes.push_back(w);
		end
		gap = sender_gap();
		repeat (gap) begin
			@(negedge clk);
			char_valid <= 1'b0;
			character  <= 8'($urandom_range(0, 255));
		end
	endtask

	function automatic logic [15:0] pick16();
		int r;
		r = $urandom_range(0, 15);
		if (r < 3) return 16'hFFFF;
		if (r < 5) return 16'h0000;
		return 16'($urandom_range(0, 65535));
	endfunction

	// hex digits, random case, now and then a stray random character
	task automatic add_hex(input logic [15:0] v, input int digits);
		logic [3:0] nib;
		logic [7:0] c;
		for (int i = digits - 1; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			if ($urandom_range(0, 39) == 0) begin
				do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CharNewline);
			end else if (nib < 4'd10) begin
				c = "0" + 8'(nib);
			end else begin
				c = ($urandom_range(0, 1) ? "A" : "a") + 8'(nib) - 8'd10;
			end
			line_buf.push_back(c);
		end
	endtask

	// one line of text: data, offset or other records, cut-short records, or junk
	task automatic build_line();
		int         pick;
		int         n;
		int         cut;
		logic [7:0] kind;
		line_buf.delete();
		pick = $urandom_range(0, 99);
		if (pick >= 88) begin
			n = $urandom_range(1, 12);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
			if (line_buf[0] == ihex_pkg::CharColon) line_buf[0] = "#";
		end else begin
			if (pick < 55 || pick >= 78) begin
				kind = ihex_pkg::KindData;
				if ($urandom_range(0, 49) == 0) begin
					n = $urandom_range(0, 1) ? 255 : $urandom_range(17, 254);
				end else if ($urandom_range(0, 9) == 0) begin
					n = 0;
				end else begin
					n = $urandom_range(1, 16);
				end
			end else if (pick < 70) begin
				kind = $urandom_range(0, 1) ? ihex_pkg::KindSegment : ihex_pkg::KindLinear;
				n = 2;
			end else begin
				do kind = 8'($urandom_range(0, 255));
				while (kind == ihex_pkg::KindData || kind == ihex_pkg::KindSegment ||
					kind == ihex_pkg::KindLinear);
				n = $urandom_range(0, 4);
			end
			line_buf.push_back(ihex_pkg::CharColon);
			add_hex(16'(n), 2);
			add_hex(pick16(), 4);
			add_hex(16'(kind), 2);
			for (int i = 0; i < n; i++) begin
				if (kind == ihex_pkg::KindData) begin
					case ($urandom_range(0, 7))
						0: add_hex(16'h00, 2);
						1: add_hex(16'hFF, 2);
						default: add_hex(16'($urandom_range(0, 255)), 2);
					endcase
				end else begin
					add_hex(16'($urandom_range(0, 255)), 2);
				end
			end
			// checksum, never checked
			add_hex(16'($urandom_range(0, 255)), 2);
			if ($urandom_range(0, 3) == 0) line_buf.push_back(8'h0D);
			if (pick >= 78) begin
				cut = $urandom_range(1, line_buf.size() - 1);
				while (line_buf.size() > cut) line_buf.delete(line_buf.size() - 1);
			end
		end
		line_buf.push_back(ihex_pkg::CharNewline);
	endtask

	// stimulus: reset, directed rows, then random lines
	initial begin : char_source
		arst_n     = 1'b0;
		char_valid <= 1'b0;
		character  <= 8'h00;
		dir_rows = '{
			// one byte FF at address 0
			row(":"), row("0"), row("1"), row("0"), row("0"), row("0"), row("0"),
			row("0"), row("0"), row("F"), row_w("F", 32'h0000_0000, 8'hFF),
			row(ihex_pkg::CharNewline),
			// junk line with extreme character codes
			row(8'hFF), row(ihex_pkg::CharColon), row(8'h00), row(ihex_pkg::CharNewline),
			// one byte 00 at address 1, checksum left out
			row(":"), row("0"), row("1"), row("0"), row("0"), row("0"), row("1"),
			row("0"), row("0"), row("0"), row_w("0", 32'h0000_0001, 8'h00),
			row(ihex_pkg::CharNewline)
		};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].w);

		while (chars_sent < RandomChars) begin
			build_line();
			foreach (line_buf[i]) send_char(line_buf[i], 1'b0, '0);
		end
		@(negedge clk);
		char_valid <= 1'b0;

		// drain, then a few cycles for anything unexpected to show up
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d characters (%0d parsed), checked %0d writes, %0d offset loads",
			chars_sent, chars_parsed, writes_seen, offset_loads);
		$display("random stalls on both sides, one hold-off of %0d cycles on the write side",
			HoldOff);
		if (errors == 0) begin
			$display("** intel_hex_record_parser: PASSED **");
		end else begin
			$display("** intel_hex_record_parser: FAILED **");
		end
		$finish;
	end

	// write side stall, with one long hold-off once traffic is flowing
	initial begin : write_sink
		int stall_run;
		stall_run = 0;
		write_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (!pressure_done && writes_seen >= 150) begin
				pressure_done = 1'b1;
				stall_run = HoldOff;
			end else if (stall_run == 0) begin
				stall_run = sink_stall();
			end
			write_stall <= (stall_run != 0);
			if (stall_run != 0) stall_run--;
		end
	end

	// compare each accepted write with the oldest prediction
	always @(posedge clk) begin
		mem_write_t exp_w;
		if (arst_n === 1'b1 && write_valid === 1'b1 && write_stall == 1'b0) begin
			writes_seen++;
			if (pending_writes.size() == 0) begin
				$error("unexpected write: address %h data %h", write_address, write_data);
				errors++;
			end else begin
				exp_w = pending_writes.pop_front();
				if (write_address !== exp_w.addr) begin
					$error("write_address: expected %h, got %h", exp_w.addr, write_address);
					errors++;
				end
				if (write_data !== exp_w.data) begin
					$error("write_data: expected %h, got %h", exp_w.data, write_data);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request taken on either side
	always @(posedge clk) begin
		cycles++;
		if ((char_valid === 1'b1 && char_stall === 1'b0) ||
				(write_valid === 1'b1 && write_stall === 1'b0)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("timeout after %0d idle cycles, %0d writes outstanding",
				idle_cycles, pending_writes.size());
			$display("** intel_hex_record_parser: FAILED **");
			$finish;
		end
	end

endmodule
